@@ sv/pfe_pkg.sv @@
// Package for the postfix expression evaluator: widths, character codes,
// status codes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package pfe_pkg;

	localparam int unsigned StackDepth = 64;
	localparam int unsigned AddrW = $clog2(StackDepth);
	localparam int unsigned DepthW = $clog2(StackDepth + 1);
	localparam int unsigned DataW = 32;
	localparam int unsigned CntW = $clog2(DataW + 1);

	localparam logic [7:0] ChPlus = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChStar = 8'h2A;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChNine = 8'h39;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StEmpty = 2'd1;
	localparam logic [1:0] StDivZero = 2'd2;
	localparam logic [1:0] StOverflow = 2'd3;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_NUM = 8'b0000_0010,
		S_RD = 8'b0000_0100,
		S_OP = 8'b0000_1000,
		S_DIV = 8'b0001_0000,
		S_PUSH = 8'b0010_0000,
		S_TOP = 8'b0100_0000,
		S_OUT = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return (c == ChPlus) || (c == ChMinus) || (c == ChStar) || (c == ChSlash)
			|| (c == ChPercent);
	endfunction

endpackage

@@ sv/pfe_if.sv @@
// Valid/ready channel interfaces for the evaluator's input and result sides.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface pfe_in_if;
	logic valid;
	logic ready;
	logic [7:0] ch;
	logic signed [31:0] var_value;
	logic last;
	modport source(output valid, ch, var_value, last, input ready);
	modport sink(input valid, ch, var_value, last, output ready);
endinterface

interface pfe_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] value;
	logic [1:0] status;
	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

@@ sv/pfe_div.sv @@
// Shared restoring divider, one quotient bit per cycle, signed truncation.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_div (
	input logic clk,
	input logic arst_n,
	input pfe_pkg::div_ctl_t ctl_in,
	input logic [pfe_pkg::DataW-1:0] a,
	input logic [pfe_pkg::DataW-1:0] b,
	input logic want_rem,
	output logic done,
	output logic [pfe_pkg::DataW-1:0] result
);
	logic [pfe_pkg::DataW-1:0] quo_q, rem_q, div_q;
	logic [pfe_pkg::CntW-1:0] cnt_q;
	logic neg_q_q, neg_r_q, rem_sel_q, run_q;
	logic [pfe_pkg::DataW:0] trial;

	assign trial = {rem_q, quo_q[pfe_pkg::DataW-1]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl_in.start) begin
			run_q <= 1'b1;
			cnt_q <= pfe_pkg::CntW'(pfe_pkg::DataW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == pfe_pkg::CntW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			quo_q <= a[pfe_pkg::DataW-1] ? -a : a;
			div_q <= b[pfe_pkg::DataW-1] ? -b : b;
			rem_q <= '0;
			neg_q_q <= a[pfe_pkg::DataW-1] ^ b[pfe_pkg::DataW-1];
			neg_r_q <= a[pfe_pkg::DataW-1];
			rem_sel_q <= want_rem;
		end else if (run_q) begin
			if (!trial[pfe_pkg::DataW]) begin
				rem_q <= trial[pfe_pkg::DataW-1:0];
				quo_q <= {quo_q[pfe_pkg::DataW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[pfe_pkg::DataW-2:0], quo_q[pfe_pkg::DataW-1]};
				quo_q <= {quo_q[pfe_pkg::DataW-2:0], 1'b0};
			end
		end
	end

	assign done = ctl_in.busy && !run_q && !ctl_in.start;
	assign result = rem_sel_q ? (neg_r_q ? -rem_q : rem_q) : (neg_q_q ? -quo_q : quo_q);
endmodule

@@ sv/postfix_expression_evaluator_unit.sv @@
// Postfix evaluator: takes one character per transfer and is ready again only in
// its idle state. A digit or a skipped character passes the decode and top
// states, a letter also a push, and + - * two stack reads, the operand fetch, the
// operate state and a push; / and % with a nonzero divisor wait there for the
// shared divider. Closing an open number adds a push before the character's own
// work. A character with last set then loads the result register, after pushing
// a still-open number, and waits while an earlier result is not yet taken. Stack is one RAM.
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit (
	input logic clk,
	input logic arst_n,
	pfe_in_if.sink in_ch,
	pfe_out_if.source out_ch
);
	localparam int unsigned W = pfe_pkg::DataW;

	pfe_pkg::state_t state_q;
	logic [7:0] ch_q;
	logic [W-1:0] var_q, accum_q, right_q, left_q, res_q, rd_q;
	logic last_q, in_num_q, num_pend_q, pop2_q;
	logic [pfe_pkg::DepthW-1:0] depth_q;
	logic [1:0] err_q;
	logic [W-1:0] stack_mem [pfe_pkg::StackDepth];
	logic [pfe_pkg::AddrW-1:0] rd_addr;
	logic [W-1:0] div_res;
	logic div_done;
	pfe_pkg::div_ctl_t div_ctl;
	logic out_v_q;
	logic [W-1:0] out_val_q;
	logic [1:0] out_st_q;
	logic [W-1:0] prod;
	logic push_full;

	assign push_full = depth_q == pfe_pkg::DepthW'(pfe_pkg::StackDepth);
	assign prod = W'(left_q * right_q);
	assign div_ctl.start = (state_q == pfe_pkg::S_OP)
		&& (ch_q == pfe_pkg::ChSlash || ch_q == pfe_pkg::ChPercent) && right_q != '0;
	assign div_ctl.busy = state_q == pfe_pkg::S_DIV;

	// The left operand is still in the read register when the divider starts.
	pfe_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(div_ctl), .a(rd_q), .b(right_q),
		.want_rem(ch_q == pfe_pkg::ChPercent), .done(div_done), .result(div_res)
	);

	// Read port: top entry, or next below when the second operand is fetched.
	assign rd_addr = pop2_q ? pfe_pkg::AddrW'(depth_q - 2'd2)
		: pfe_pkg::AddrW'(depth_q - 1'b1);
	always_ff @(posedge clk) begin
		rd_q <= stack_mem[rd_addr];
		if (state_q == pfe_pkg::S_PUSH && !push_full) begin
			stack_mem[pfe_pkg::AddrW'(depth_q)] <= res_q;
		end
	end

	assign in_ch.ready = state_q == pfe_pkg::S_IDLE;
	assign out_ch.valid = out_v_q;
	assign out_ch.value = out_val_q;
	assign out_ch.status = out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::S_IDLE;
			depth_q <= '0;
			accum_q <= '0;
			in_num_q <= 1'b0;
			err_q <= pfe_pkg::StOk;
			out_v_q <= 1'b0;
			num_pend_q <= 1'b0;
			pop2_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				pfe_pkg::S_IDLE: begin
					if (in_ch.valid) begin
						ch_q <= in_ch.ch;
						var_q <= in_ch.var_value;
						last_q <= in_ch.last;
						state_q <= pfe_pkg::S_NUM;
					end
				end
				pfe_pkg::S_NUM: begin
					num_pend_q <= 1'b0;
					if (pfe_pkg::is_digit(ch_q)) begin
						accum_q <= W'((in_num_q ? accum_q : '0) * 4'd10)
							+ W'(ch_q - pfe_pkg::ChZero);
						in_num_q <= 1'b1;
						state_q <= pfe_pkg::S_TOP;
					end else if (in_num_q) begin
						in_num_q <= 1'b0;
						res_q <= accum_q;
						num_pend_q <= 1'b1;
						state_q <= pfe_pkg::S_PUSH;
					end else if (pfe_pkg::is_letter(ch_q)) begin
						res_q <= var_q;
						ch_q <= 8'h20;
						state_q <= pfe_pkg::S_PUSH;
					end else if (pfe_pkg::is_oper(ch_q) && depth_q >= pfe_pkg::DepthW'(2)) begin
						state_q <= pfe_pkg::S_RD;
					end else begin
						state_q <= pfe_pkg::S_TOP;
					end
				end
				pfe_pkg::S_RD: begin
					// Two reads: top first, then the entry below it.
					if (!pop2_q) begin
						pop2_q <= 1'b1;
					end else begin
						right_q <= rd_q;
						pop2_q <= 1'b0;
						state_q <= pfe_pkg::S_OP;
					end
				end
				pfe_pkg::S_OP: begin
					left_q <= rd_q;
					state_q <= pfe_pkg::S_DIV;
				end
				pfe_pkg::S_DIV: begin
					if (ch_q == pfe_pkg::ChPlus) begin
						res_q <= left_q + right_q;
						depth_q <= depth_q - 2'd2;
						state_q <= pfe_pkg::S_PUSH;
					end else if (ch_q == pfe_pkg::ChMinus) begin
						res_q <= left_q - right_q;
						depth_q <= depth_q - 2'd2;
						state_q <= pfe_pkg::S_PUSH;
					end else if (ch_q == pfe_pkg::ChStar) begin
						res_q <= prod;
						depth_q <= depth_q - 2'd2;
						state_q <= pfe_pkg::S_PUSH;
					end else if (right_q == '0) begin
						res_q <= '0;
						if (err_q == pfe_pkg::StOk) err_q <= pfe_pkg::StDivZero;
						depth_q <= depth_q - 2'd2;
						state_q <= pfe_pkg::S_PUSH;
					end else if (div_done) begin
						res_q <= div_res;
						depth_q <= depth_q - 2'd2;
						state_q <= pfe_pkg::S_PUSH;
					end
				end
				pfe_pkg::S_PUSH: begin
					if (push_full) begin
						if (err_q == pfe_pkg::StOk) err_q <= pfe_pkg::StOverflow;
					end else begin
						depth_q <= depth_q + 1'b1;
					end
					// A closed number is followed by the character's own work.
					if (num_pend_q) begin
						state_q <= pfe_pkg::S_NUM;
					end else if (pfe_pkg::is_letter(ch_q) || pfe_pkg::is_oper(ch_q)) begin
						ch_q <= 8'h20;
						state_q <= pfe_pkg::S_TOP;
					end else begin
						state_q <= pfe_pkg::S_TOP;
					end
				end
				pfe_pkg::S_TOP: begin
					if (!last_q) begin
						state_q <= pfe_pkg::S_IDLE;
					end else if (in_num_q) begin
						in_num_q <= 1'b0;
						res_q <= accum_q;
						ch_q <= 8'h20;
						state_q <= pfe_pkg::S_PUSH;
					end else if (!out_v_q || out_ch.ready) begin
						state_q <= pfe_pkg::S_OUT;
					end
				end
				pfe_pkg::S_OUT: begin
					out_v_q <= 1'b1;
					out_val_q <= (depth_q == '0) ? '0 : rd_q;
					out_st_q <= (err_q != pfe_pkg::StOk) ? err_q
						: ((depth_q == '0) ? pfe_pkg::StEmpty : pfe_pkg::StOk);
					depth_q <= '0;
					accum_q <= '0;
					in_num_q <= 1'b0;
					err_q <= pfe_pkg::StOk;
					state_q <= pfe_pkg::S_IDLE;
				end
				default: state_q <= pfe_pkg::S_IDLE;
			endcase
		end
	end
endmodule

@@ test/tb_top.sv @@
// Self-checking bench for postfix_expression_evaluator_unit: a queue-fed driver,
// an output monitor and a predictor of the evaluator. Depends on pfe_pkg and pfe_if.
`timescale 1ns / 1ps

module tb_top;
	typedef struct {
		logic [7:0] ch;
		logic [31:0] var_value;
		logic last;
	} char_item_t;

	typedef struct {
		logic [31:0] value;
		logic [1:0] status;
	} eval_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	pfe_in_if in_ch ();
	pfe_out_if out_ch ();

	postfix_expression_evaluator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	char_item_t pending_chars[$];
	eval_result_t expected_results[$];
	int unsigned error_count = 0;
	int unsigned result_count = 0;
	int unsigned char_count = 0;
	int unsigned cycle_count = 0;
	bit idle_off = 1'b0;
	bit hold_for_drain = 1'b0;

	// Predictor state.
	logic [31:0] pr_stack[pfe_pkg::StackDepth];
	int unsigned pr_depth = 0;
	logic [31:0] pr_accum = '0;
	bit pr_in_num = 1'b0;
	logic [1:0] pr_err = pfe_pkg::StOk;

	function automatic void pr_note(logic [1:0] code);
		if (pr_err == pfe_pkg::StOk)
			pr_err = code;
	endfunction

	function automatic void pr_push(logic [31:0] v);
		if (pr_depth < pfe_pkg::StackDepth) begin
			pr_stack[pr_depth] = v;
			pr_depth++;
		end else
			pr_note(pfe_pkg::StOverflow);
	endfunction

	function automatic logic [31:0] quot_or_rem(logic [31:0] a, logic [31:0] b, bit rem);
		logic [31:0] ma, mb, q, r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (rem)
			return a[31] ? -r : r;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic void pr_operator(logic [7:0] op);
		logic [31:0] rhs, lhs, res;
		if (pr_depth < 2)
			return;
		rhs = pr_stack[pr_depth - 1];
		lhs = pr_stack[pr_depth - 2];
		pr_depth -= 2;
		case (op)
			pfe_pkg::ChPlus: res = lhs + rhs;
			pfe_pkg::ChMinus: res = lhs - rhs;
			pfe_pkg::ChStar: res = lhs * rhs;
			default: begin
				if (rhs == 0) begin
					pr_note(pfe_pkg::StDivZero);
					res = '0;
				end else
					res = quot_or_rem(lhs, rhs, op == pfe_pkg::ChPercent);
			end
		endcase
		pr_push(res);
	endfunction

	function automatic void evaluate_char(char_item_t it);
		eval_result_t r;
		logic [7:0] c;
		c = it.ch;
		if (c >= pfe_pkg::ChZero && c <= pfe_pkg::ChNine) begin
			if (!pr_in_num) begin
				pr_in_num = 1'b1;
				pr_accum = '0;
			end
			pr_accum = pr_accum * 32'd10 + 32'(c - pfe_pkg::ChZero);
		end else begin
			if (pr_in_num) begin
				pr_in_num = 1'b0;
				pr_push(pr_accum);
			end
			if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
				pr_push(it.var_value);
			else if (c == pfe_pkg::ChPlus || c == pfe_pkg::ChMinus || c == pfe_pkg::ChStar
					|| c == pfe_pkg::ChSlash || c == pfe_pkg::ChPercent)
				pr_operator(c);
		end
		if (!it.last)
			return;
		if (pr_in_num) begin
			pr_in_num = 1'b0;
			pr_push(pr_accum);
		end
		r.value = (pr_depth >= 1) ? pr_stack[pr_depth - 1] : '0;
		if (pr_err != pfe_pkg::StOk)
			r.status = pr_err;
		else if (pr_depth == 0)
			r.status = pfe_pkg::StEmpty;
		else
			r.status = pfe_pkg::StOk;
		expected_results.push_back(r);
		pr_depth = 0;
		pr_accum = '0;
		pr_in_num = 1'b0;
		pr_err = pfe_pkg::StOk;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR t=%0t result %0d: %s got %h expected %h", $time, result_count,
			what, got, want);
		error_count++;
	endtask

	// Driver.
	int unsigned in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.ch <= '0;
			in_ch.var_value <= '0;
			in_ch.last <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				evaluate_char(pending_chars.pop_front());
				char_count++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (in_gap > 0)
					in_gap--;
				else if (!idle_off && $urandom_range(0, 19) == 0)
					in_gap = $urandom_range(1, 9);
				if (in_gap == 0 && !hold_for_drain && pending_chars.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.ch <= pending_chars[0].ch;
					in_ch.var_value <= pending_chars[0].var_value;
					in_ch.last <= pending_chars[0].last;
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor.
	int unsigned out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		eval_result_t want;
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected value", out_ch.value, '0);
				end else begin
					want = expected_results.pop_front();
					if (out_ch.value !== want.value)
						report_mismatch("value", out_ch.value, want.value);
					if (out_ch.status !== want.status)
						report_mismatch("status", 32'(out_ch.status), 32'(want.status));
				end
				result_count++;
			end
			if (out_gap > 0)
				out_gap--;
			else if (!idle_off && $urandom_range(0, 15) == 0)
				out_gap = $urandom_range(1, 9);
			out_ch.ready <= (out_gap == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 600000) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void add_char(logic [7:0] c, logic [31:0] v = '0, logic l = 1'b0);
		char_item_t it;
		it.ch = c;
		it.var_value = v;
		it.last = l;
		pending_chars.push_back(it);
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 4))
			0: return pfe_pkg::ChPlus;
			1: return pfe_pkg::ChMinus;
			2: return pfe_pkg::ChStar;
			3: return pfe_pkg::ChSlash;
			default: return pfe_pkg::ChPercent;
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'(0);
			3: return 32'($urandom_range(0, 9));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
			: 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	// One expression: random operand/operator mixes, some noise.
	function automatic void add_expression();
		int unsigned n;
		n = $urandom_range(1, 14);
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					for (int unsigned d = $urandom_range(1, 11); d > 0; d--)
						add_char(8'(pfe_pkg::ChZero + $urandom_range(0, 9)), $urandom);
					add_char(8'h20, $urandom);
				end
				3, 4, 5: add_char(pick_letter(), pick_value());
				6, 7, 8: add_char(pick_operator(), $urandom);
				default: add_char(8'($urandom_range(0, 255)), $urandom);
			endcase
		end
		add_char($urandom_range(0, 1) ? pick_operator() : 8'h20, $urandom, 1'b1);
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		add_char(8'h41, 32'h8000_0000);
		add_char(8'h61, 32'hFFFF_FFFF);
		add_char(pfe_pkg::ChSlash);
		add_char(8'h7A, 32'h8000_0000);
		add_char(8'h5A, 32'hFFFF_FFFF, 1'b0);
		add_char(pfe_pkg::ChPercent, 32'h0, 1'b1);
		add_char(8'h39);
		add_char(8'h28);
		add_char(8'h30);
		add_char(pfe_pkg::ChSlash, 32'hFFFF_FFFF, 1'b1);
		add_char(pfe_pkg::ChPlus, 32'h0, 1'b1);
		add_char(8'h34);
		add_char(8'h32);
		add_char(8'h39);
		add_char(8'h34);
		add_char(8'h39);
		add_char(8'h36);
		add_char(8'h37);
		add_char(8'h32);
		add_char(8'h39);
		add_char(8'h37);
		add_char(8'h37, 32'h0, 1'b1);
		add_char(8'h37, 32'h0, 1'b0);
		add_char(8'h33, 32'h0, 1'b0);
		add_char(pfe_pkg::ChMinus, 32'h0, 1'b0);
		add_char(pfe_pkg::ChStar, 32'h0, 1'b0);
		add_char(8'hFF, 32'h0, 1'b1);

		// Overflow: more pushes than the stack holds.
		for (int i = 0; i < pfe_pkg::StackDepth + 2; i++)
			add_char(8'h61, $urandom);
		add_char(pfe_pkg::ChPlus, 32'h0, 1'b1);

		for (int i = 0; i < 35; i++)
			add_expression();

		wait (pending_chars.size() == 0);
		hold_for_drain = 1'b1;
		wait (expected_results.size() == 0);
		repeat (60) @(posedge clk);
		hold_for_drain = 1'b0;

		for (int i = 0; i < 10; i++)
			add_expression();
		wait (pending_chars.size() < 50);
		idle_off = 1'b1;
		for (int i = 0; i < 5; i++)
			add_expression();
		wait (pending_chars.size() == 0);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);

		$display("Ran %0d characters, checked %0d expression results.", char_count,
			result_count);
		if (error_count == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ postfix_expression_evaluator_unit.f @@
sv/pfe_pkg.sv
sv/pfe_if.sv
sv/pfe_div.sv
sv/postfix_expression_evaluator_unit.sv
test/tb_top.sv
